### src/fap_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Filename pattern access filter package
// Beat type carried along the cell chain, flag masks and outcome codes.
// ----------------------------------------------------------------------------
package fap_pkg;

  localparam logic [31:0] FLAG_ACCMODE = 32'h0000_0003;
  localparam logic [31:0] FLAG_CREATE  = 32'h0000_0040;

  typedef enum logic [2:0] {
    OUT_UNPROTECTED   = 3'd0,
    OUT_WRITE_ALLOWED = 3'd1,
    OUT_WRITE_DENIED  = 3'd2,
    OUT_READ_ALLOWED  = 3'd3,
    OUT_READ_BLOCKED  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic       valid;
    logic       is_name;
    logic       tsel;
    logic [4:0] slot;
    logic [3:0] pos;
    logic [7:0] data;
    logic       adv;
    logic       may_start;
    logic       last;
    logic       wr_req;
    logic       prot;
    logic       hit_w;
    logic       hit_b;
  } beat_t;

endpackage
`default_nettype wire

### src/fap_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern cell
// Holds one slot of both pattern tables and its partial-match vectors, and
// passes each beat on to the next cell with the running hit bits.
// ----------------------------------------------------------------------------
module fap_cell import fap_pkg::*; #(
  parameter int IDX         = 0,
  parameter int PATTERN_LEN = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  enable,
  input  beat_t beat_in,
  output beat_t beat_out
);

  logic [7:0]             pat [2][PATTERN_LEN];
  logic [PATTERN_LEN-1:0] vec [2];
  logic [PATTERN_LEN-1:0] vec_next [2];
  logic [PATTERN_LEN:0]   nz [2];
  logic [PATTERN_LEN-1:0] pre [2];
  logic [PATTERN_LEN-1:0] eq [2];
  logic [PATTERN_LEN-1:0] tail_mask [2];
  logic [1:0]             hit;
  beat_t                  beat_next;

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      nz[t][PATTERN_LEN] = 1'b0;
      for (int j = 0; j < PATTERN_LEN; j++) begin
        nz[t][j] = (pat[t][j] != 8'd0);
      end
      pre[t][0] = nz[t][0];
      for (int j = 1; j < PATTERN_LEN; j++) begin
        pre[t][j] = pre[t][j-1] & nz[t][j];
      end
      for (int j = 0; j < PATTERN_LEN; j++) begin
        eq[t][j]        = pre[t][j] && (pat[t][j] == beat_in.data);
        tail_mask[t][j] = pre[t][j] & ~nz[t][j+1];
      end
      vec_next[t] = {vec[t][PATTERN_LEN-2:0], beat_in.may_start} & eq[t];
      hit[t]      = |(vec_next[t] & tail_mask[t]);
    end
  end

  always_comb begin
    beat_next = beat_in;
    if (beat_in.valid && beat_in.is_name && beat_in.adv) begin
      beat_next.hit_w = beat_in.hit_w | hit[0];
      beat_next.hit_b = beat_in.hit_b | hit[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < 2; t++) begin
        vec[t] <= '0;
        for (int j = 0; j < PATTERN_LEN; j++) begin
          pat[t][j] <= '0;
        end
      end
    end else if (enable && beat_in.valid) begin
      if (!beat_in.is_name) begin
        if (int'(beat_in.slot) == IDX) begin
          for (int j = 0; j < PATTERN_LEN; j++) begin
            if (int'(beat_in.pos) == j) begin
              pat[beat_in.tsel][j] <= beat_in.data;
            end
          end
        end
      end else if (beat_in.last) begin
        vec[0] <= '0;
        vec[1] <= '0;
      end else if (beat_in.adv) begin
        vec[0] <= vec_next[0];
        vec[1] <= vec_next[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out <= '0;
    end else if (enable) begin
      beat_out <= beat_next;
    end
  end

endmodule
`default_nettype wire

### src/filename_pattern_access_filter_unit.sv
// A decision is registered once its final name beat has passed through every
// pattern cell's beat register in the chain and then the output register.
// Throughput: one beat per cycle; the whole chain holds while a decision waits.
// Reset clears the pattern tables, the match vectors and the name state at once.
`default_nettype none
// ----------------------------------------------------------------------------
// Filename pattern access filter
// Streams pattern-table writes and filename bytes through a chain of pattern
// cells and decides the open request on the final name byte.
// ----------------------------------------------------------------------------
module filename_pattern_access_filter_unit import fap_pkg::*; #(
  parameter int PATTERN_SLOTS = 32,
  parameter int PATTERN_LEN   = 16,
  parameter int START_LIMIT   = 64,
  parameter int NAME_MAX_LEN  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic        table_select,
  input  logic [4:0]  pattern_slot,
  input  logic [3:0]  pattern_pos,
  input  logic [7:0]  pattern_byte,
  input  logic [7:0]  name_byte,
  input  logic        name_last,
  input  logic [31:0] open_flags,
  input  logic        caller_protected,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        permit,
  output logic        report_event,
  output logic [2:0]  outcome
);

  localparam int NPOS_W = $clog2(NAME_MAX_LEN);

  logic              enable;
  logic              accept;
  logic [NPOS_W-1:0] name_position;
  logic              name_ended;
  logic              adv;
  beat_t             head;
  beat_t             link [PATTERN_SLOTS+1];
  beat_t             tail;
  logic              write_hit_flag;
  logic              block_hit_flag;
  logic              any_w;
  logic              any_b;
  logic              permit_next;
  logic              report_next;
  outcome_t          outcome_next;

  assign enable   = !(out_valid && !out_ready);
  assign in_ready = enable;
  assign accept   = in_valid && in_ready;

  assign adv = kind && !name_ended && (name_byte != 8'd0) &&
               (name_position < NPOS_W'(NAME_MAX_LEN - 1));

  always_comb begin
    head           = '0;
    head.valid     = accept;
    head.is_name   = kind;
    head.tsel      = table_select;
    head.slot      = pattern_slot;
    head.pos       = pattern_pos;
    head.data      = kind ? name_byte : pattern_byte;
    head.adv       = adv;
    head.may_start = int'(name_position) < START_LIMIT;
    head.last      = kind && name_last;
    head.wr_req    = ((open_flags & FLAG_ACCMODE) != '0) ||
                     ((open_flags & FLAG_CREATE) != '0);
    head.prot      = caller_protected;
  end

  assign link[0] = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_position <= '0;
      name_ended    <= 1'b0;
    end else if (accept && kind) begin
      if (name_last) begin
        name_position <= '0;
        name_ended    <= 1'b0;
      end else begin
        if (!name_ended && name_byte == 8'd0) begin
          name_ended <= 1'b1;
        end
        if (adv) begin
          name_position <= name_position + 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < PATTERN_SLOTS; i++) begin : g_cell
    fap_cell #(
      .IDX         (i),
      .PATTERN_LEN (PATTERN_LEN)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .enable   (enable),
      .beat_in  (link[i]),
      .beat_out (link[i+1])
    );
  end

  assign tail  = link[PATTERN_SLOTS];
  assign any_w = write_hit_flag | tail.hit_w;
  assign any_b = block_hit_flag | tail.hit_b;

  always_comb begin
    if (!tail.prot) begin
      permit_next  = 1'b1;
      report_next  = 1'b0;
      outcome_next = OUT_UNPROTECTED;
    end else if (tail.wr_req) begin
      permit_next  = any_w;
      report_next  = !any_w;
      outcome_next = any_w ? OUT_WRITE_ALLOWED : OUT_WRITE_DENIED;
    end else begin
      permit_next  = !any_b;
      report_next  = 1'b1;
      outcome_next = any_b ? OUT_READ_BLOCKED : OUT_READ_ALLOWED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_hit_flag <= 1'b0;
      block_hit_flag <= 1'b0;
      out_valid      <= 1'b0;
    end else if (enable) begin
      if (tail.valid && tail.is_name) begin
        if (tail.last) begin
          write_hit_flag <= 1'b0;
          block_hit_flag <= 1'b0;
        end else begin
          write_hit_flag <= any_w;
          block_hit_flag <= any_b;
        end
      end
      out_valid <= tail.valid && tail.is_name && tail.last;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      permit       <= permit_next;
      report_event <= report_next;
      outcome      <= outcome_next;
    end
  end

`ifndef ASSERT_OFF
  a_permit_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (permit == (outcome == OUT_UNPROTECTED ||
                              outcome == OUT_WRITE_ALLOWED ||
                              outcome == OUT_READ_ALLOWED)))
    else $error("permit disagrees with outcome");

  a_report_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (report_event == (outcome == OUT_WRITE_DENIED ||
                                    outcome == OUT_READ_ALLOWED ||
                                    outcome == OUT_READ_BLOCKED)))
    else $error("report_event disagrees with outcome");

  a_name_restart : assert property (@(posedge clk) disable iff (rst)
    (accept && kind && name_last) |=> (name_position == '0 && !name_ended))
    else $error("name state not cleared after final beat");

  a_position_bound : assert property (@(posedge clk) disable iff (rst)
    name_position <= NPOS_W'(NAME_MAX_LEN - 1))
    else $error("name position beyond maximum length");
`endif

endmodule
`default_nettype wire
